/* rtl/besev_pkg.sv */
// ----------------------------------------------------------------------------
// besev_pkg
// Shared types and constants of the boolean expression stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package besev_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_INPUTS  = 9;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int BITS_W      = 9;
    localparam int BIT_IDX_W   = 4;

    // ASCII characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AND   = 8'h26;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_OR    = 8'h7C;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        OPC_OPEN  = 3'd0,
        OPC_NOT   = 3'd1,
        OPC_AND   = 3'd2,
        OPC_OR    = 3'd3,
        OPC_OTHER = 3'd4
    } t_opc;

    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_LOAD     = 4'd1,   // capture the accepted request
        CMD_DIGIT    = 4'd2,   // push the selected input bit
        CMD_NEG_I    = 4'd3,   // '~' followed by 'i'
        CMD_PUSH_NOT = 4'd4,   // deferred '~' becomes an operator
        CMD_HANDLE   = 4'd5,   // plain character handling
        CMD_TRAIL    = 4'd6,   // end-of-expression fixups
        CMD_POP_OP   = 4'd7,   // drop the top operator
        CMD_POP_NOT  = 4'd8,   // drop '~' and invert top value
        CMD_POP_B    = 4'd9,   // drop binary operator, pop right operand
        CMD_APPLY2   = 4'd10,  // pop left operand, push result
        CMD_FINISH   = 4'd11   // emit result and clear
    } t_cmd;

    typedef struct packed {
        logic [7:0]        char_code;
        logic [BITS_W-1:0] input_bits;
        logic              last_char;
    } t_in_req;

    typedef struct packed {
        logic result_bit;
        logic error_flag;
    } t_out_req;

    typedef struct packed {
        logic awaiting;
        logic pending;
        logic is_i;
        logic is_close;
        logic last;
        logic op_empty;
        t_opc top_op;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/besev_ctrl.sv */
// ----------------------------------------------------------------------------
// besev_ctrl
// Sequencer: walks characters through the datapath one step per cycle unless held.
// ----------------------------------------------------------------------------
`default_nettype none

module besev_ctrl
    import besev_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_out_free,
    input  wire t_dp_status i_status,
    output logic            o_busy,
    output t_cmd            o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FIRST    = 8'b0000_0010,
        S_HANDLE   = 8'b0000_0100,
        S_CLOSE    = 8'b0000_1000,
        S_CL_APPLY = 8'b0001_0000,
        S_END      = 8'b0010_0000,
        S_REDUCE   = 8'b0100_0000,
        S_RD_APPLY = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_state s_done;

    assign s_done = i_status.last ? S_END : S_IDLE;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                priority if (i_status.awaiting) begin
                    o_cmd   = CMD_DIGIT;
                    n_state = s_done;
                end else if (i_status.pending && i_status.is_i) begin
                    o_cmd   = CMD_NEG_I;
                    n_state = s_done;
                end else if (i_status.pending) begin
                    o_cmd   = CMD_PUSH_NOT;
                    n_state = S_HANDLE;
                end else if (i_status.is_close) begin
                    n_state = S_CLOSE;
                end else begin
                    o_cmd   = CMD_HANDLE;
                    n_state = s_done;
                end
            end
            S_HANDLE: begin
                if (i_status.is_close) begin
                    n_state = S_CLOSE;
                end else begin
                    o_cmd   = CMD_HANDLE;
                    n_state = s_done;
                end
            end
            S_CLOSE: begin
                priority if (i_status.op_empty) begin
                    n_state = s_done;
                end else if (i_status.top_op == OPC_OPEN) begin
                    o_cmd   = CMD_POP_OP;
                    n_state = s_done;
                end else if (i_status.top_op == OPC_NOT) begin
                    o_cmd   = CMD_POP_NOT;
                end else begin
                    o_cmd   = CMD_POP_B;
                    n_state = S_CL_APPLY;
                end
            end
            S_CL_APPLY: begin
                o_cmd   = CMD_APPLY2;
                n_state = S_CLOSE;
            end
            S_END: begin
                o_cmd   = CMD_TRAIL;
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                // an open bracket left at the end reduces like an unknown operator
                priority if (i_status.op_empty) begin
                    if (i_out_free) begin
                        o_cmd   = CMD_FINISH;
                        n_state = S_IDLE;
                    end
                end else if (i_status.top_op == OPC_NOT) begin
                    o_cmd   = CMD_POP_NOT;
                end else begin
                    o_cmd   = CMD_POP_B;
                    n_state = S_RD_APPLY;
                end
            end
            S_RD_APPLY: begin
                o_cmd   = CMD_APPLY2;
                n_state = S_REDUCE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/besev_dp.sv */
// ----------------------------------------------------------------------------
// besev_dp
// Datapath: value and operator stacks, parser flags and the error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module besev_dp
    import besev_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire t_in_req i_in_data,
    output t_dp_status   o_status,
    output t_out_req     o_result
);

    // stacks (contents undefined until pushed)
    logic r_vs [STACK_DEPTH];
    t_opc r_os [STACK_DEPTH];

    logic [CNT_W-1:0]  r_vc, n_vc, r_oc, n_oc;
    logic              r_pend, n_pend, r_inv, n_inv, r_await, n_await, r_err, n_err;
    logic [7:0]        r_char;
    logic [BITS_W-1:0] r_bits;
    logic              r_last;
    logic              r_b, n_b;
    t_opc              r_op, n_op;

    logic [CNT_W-1:0] vc_m1, oc_m1;
    logic             v_top, v_empty, v_full, o_full;
    t_opc             o_top;

    logic             vs_we, vs_wd;
    logic [IDX_W-1:0] vs_wa;
    logic             val_push, val_push_v;
    logic             op_push;
    t_opc             op_push_code;

    logic [7:0]           dig_off;
    logic                 dig_ok;
    logic                 dig_v;
    logic                 lhs, res;

    assign vc_m1   = r_vc - CNT_W'(1);
    assign oc_m1   = r_oc - CNT_W'(1);
    assign v_top   = r_vs[vc_m1[IDX_W-1:0]];
    assign o_top   = r_os[oc_m1[IDX_W-1:0]];
    assign v_empty = (r_vc == '0);
    assign v_full  = (r_vc == CNT_W'(STACK_DEPTH));
    assign o_full  = (r_oc == CNT_W'(STACK_DEPTH));

    assign dig_off = r_char - CH_ONE;
    assign dig_ok  = (r_char >= CH_ONE) && (dig_off < 8'(NUM_INPUTS));
    assign dig_v   = dig_ok ? r_bits[dig_off[BIT_IDX_W-1:0]] : 1'b0;
    assign lhs     = v_empty ? 1'b0 : v_top;

    always_comb begin
        unique case (r_op)
            OPC_AND: res = lhs & r_b;
            OPC_OR:  res = lhs | r_b;
            default: res = 1'b1;
        endcase
    end

    always_comb begin
        n_vc         = r_vc;
        n_oc         = r_oc;
        n_pend       = r_pend;
        n_inv        = r_inv;
        n_await      = r_await;
        n_err        = r_err;
        n_b          = r_b;
        n_op         = r_op;
        vs_we        = 1'b0;
        vs_wa        = vc_m1[IDX_W-1:0];
        vs_wd        = 1'b0;
        val_push     = 1'b0;
        val_push_v   = 1'b0;
        op_push      = 1'b0;
        op_push_code = OPC_NOT;

        unique case (i_cmd)
            CMD_DIGIT: begin
                n_await    = 1'b0;
                n_inv      = 1'b0;
                val_push   = 1'b1;
                val_push_v = dig_v ^ r_inv;
                if (!dig_ok) begin
                    n_err = 1'b1;
                end
            end
            CMD_NEG_I: begin
                n_pend  = 1'b0;
                n_inv   = 1'b1;
                n_await = 1'b1;
            end
            CMD_PUSH_NOT: begin
                n_pend  = 1'b0;
                op_push = 1'b1;
            end
            CMD_HANDLE: begin
                priority if (r_char == CH_SPACE) begin
                end else if (r_char == CH_I) begin
                    n_await = 1'b1;
                end else if (r_char == CH_TILDE) begin
                    n_pend = 1'b1;
                end else begin
                    op_push = 1'b1;
                    priority if (r_char == CH_OPEN) begin
                        op_push_code = OPC_OPEN;
                    end else if (r_char == CH_AND) begin
                        op_push_code = OPC_AND;
                    end else if (r_char == CH_OR) begin
                        op_push_code = OPC_OR;
                    end else begin
                        op_push_code = OPC_OTHER;
                    end
                end
            end
            CMD_TRAIL: begin
                if (r_await) begin
                    n_err = 1'b1;
                end
                n_await = 1'b0;
                n_pend  = 1'b0;
                op_push = r_pend;
            end
            CMD_POP_OP: begin
                n_oc = oc_m1;
            end
            CMD_POP_NOT: begin
                n_oc  = oc_m1;
                vs_we = 1'b1;
                if (v_empty) begin
                    // underflow pops 0, inverted result lands at the bottom
                    n_err = 1'b1;
                    n_vc  = CNT_W'(1);
                    vs_wa = '0;
                    vs_wd = 1'b1;
                end else begin
                    vs_wd = ~v_top;
                end
            end
            CMD_POP_B: begin
                n_oc = oc_m1;
                n_op = o_top;
                if (v_empty) begin
                    n_err = 1'b1;
                    n_b   = 1'b0;
                end else begin
                    n_b  = v_top;
                    n_vc = vc_m1;
                end
            end
            CMD_APPLY2: begin
                vs_we = 1'b1;
                vs_wd = res;
                if (v_empty) begin
                    n_err = 1'b1;
                    n_vc  = CNT_W'(1);
                    vs_wa = '0;
                end
            end
            CMD_FINISH: begin
                n_vc    = '0;
                n_oc    = '0;
                n_pend  = 1'b0;
                n_inv   = 1'b0;
                n_await = 1'b0;
                n_err   = 1'b0;
            end
            default: begin
            end
        endcase

        if (val_push) begin
            if (v_full) begin
                n_err = 1'b1;
            end else begin
                vs_we = 1'b1;
                vs_wa = r_vc[IDX_W-1:0];
                vs_wd = val_push_v;
                n_vc  = r_vc + CNT_W'(1);
            end
        end
        if (op_push) begin
            if (o_full) begin
                n_err = 1'b1;
            end else begin
                n_oc = r_oc + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc    <= '0;
            r_oc    <= '0;
            r_pend  <= 1'b0;
            r_inv   <= 1'b0;
            r_await <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_vc    <= n_vc;
            r_oc    <= n_oc;
            r_pend  <= n_pend;
            r_inv   <= n_inv;
            r_await <= n_await;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b  <= n_b;
        r_op <= n_op;
        if (i_cmd == CMD_LOAD) begin
            r_char <= i_in_data.char_code;
            r_bits <= i_in_data.input_bits;
            r_last <= i_in_data.last_char;
        end
        if (vs_we) begin
            r_vs[vs_wa] <= vs_wd;
        end
        if (op_push && !o_full) begin
            r_os[r_oc[IDX_W-1:0]] <= op_push_code;
        end
    end

    assign o_status.awaiting = r_await;
    assign o_status.pending  = r_pend;
    assign o_status.is_i     = (r_char == CH_I);
    assign o_status.is_close = (r_char == CH_CLOSE);
    assign o_status.last     = r_last;
    assign o_status.op_empty = (r_oc == '0);
    assign o_status.top_op   = o_top;

    assign o_result.result_bit = lhs;
    assign o_result.error_flag = r_err | v_empty;

endmodule

`default_nettype wire

/* rtl/boolean_expression_stack_evaluator_core.sv */
// ----------------------------------------------------------------------------
// boolean_expression_stack_evaluator_core
// Streaming two-stack evaluator of a gate's boolean expression.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one character
//   request per accepted cycle, with the gate's input bits alongside and
//   last_char marking the final character of the expression.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//   request per expression: the result bit and a sticky error flag.
// Sequencing:
//   An ordinary character is accepted, then takes one datapath step; a
//   deferred '~' that turns into an operator adds a step of its own.
//   A ')' and the end of the expression pop the operator stack one operator
//   at a time through the single value-stack port; a binary operator is
//   popped and then applied. After the last character come the trailing
//   fixups, the reduction and the finish step that registers the result.
// Reset (synchronous, active low) empties both stacks and clears the parser, error and output-valid flags.
// A stalled result stays in the output register; the block keeps accepting
// characters meanwhile and holds off only when the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module boolean_expression_stack_evaluator_core
    import besev_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_req      o_out_data
);

    t_cmd       cmd;
    t_dp_status dp_status;
    t_out_req   dp_result;
    logic       busy;
    logic       out_free;

    logic       r_out_vld;
    t_out_req   r_out;

    // output register can take a new request when empty or draining this cycle
    assign out_free = !r_out_vld || !i_out_stall;

    besev_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    besev_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_data (i_in_data),
        .o_status  (dp_status),
        .o_result  (dp_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (cmd == CMD_FINISH) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd == CMD_FINISH) begin
            r_out <= dp_result;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/besev_chk.sv */
// ----------------------------------------------------------------------------
// besev_chk
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module besev_chk
    import besev_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_in_req  i_in_data,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_req o_out_data
);

    // stalled character request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled character request dropped or changed");

    // stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result request dropped or changed");

    // every accepted character needs at least one more step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a result never appears right after a character is accepted
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result too soon after accept");

    // after a result is issued the block is ready for the next expression
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("block busy when result issued");

endmodule

bind boolean_expression_stack_evaluator_core besev_chk u_besev_chk (.*);

`default_nettype wire
